// File: sv/source_lexer_token_classifier_macros.svh
// Assertion macros for the source lexer token classifier.
// Depends on nothing; the including module must provide clock and reset.
`ifndef SOURCE_LEXER_TOKEN_CLASSIFIER_MACROS_SVH
`define SOURCE_LEXER_TOKEN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define SLC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

`endif

// File: sv/slc_pkg.sv
// Shared types, constants and lookup functions for the source lexer.
// No dependencies; imported by every module of the block.
`default_nettype none

package slc_pkg;

   localparam int COLUMN_BITS = 16;
   localparam int LINE_BITS   = 32;
   localparam int KIND_BITS   = 4;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_START_LINE = 1'b0;

   localparam int RSP_PAYLOAD_BITS = KIND_BITS + LINE_BITS + 2 * COLUMN_BITS;
   localparam int RSP_DATA_BITS    = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_BITS  = $clog2(FIFO_DEPTH + 1);

   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

   localparam logic CLASS_NAME   = 1'b0;
   localparam logic CLASS_NUMBER = 1'b1;

   localparam logic [7:0] CH_NEWLINE    = 8'h0a;
   localparam logic [7:0] CH_LBRACE     = 8'h7b;
   localparam logic [7:0] CH_RBRACE     = 8'h7d;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_POINT      = 8'h2e;
   localparam logic [7:0] CH_COLON      = 8'h3a;
   localparam logic [7:0] CH_SEMICOLON  = 8'h3b;
   localparam logic [7:0] CH_COMMA      = 8'h2c;
   localparam logic [7:0] CH_EQUAL      = 8'h3d;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;
   localparam logic [7:0] CH_F          = 8'h66;
   localparam logic [7:0] CH_N          = 8'h6e;
   localparam logic [7:0] CH_T          = 8'h74;
   localparam logic [7:0] CH_Y          = 8'h79;
   localparam logic [7:0] CH_P          = 8'h70;
   localparam logic [7:0] CH_E          = 8'h65;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NAME      = 4'd0,
      KIND_LBRACE    = 4'd1,
      KIND_RBRACE    = 4'd2,
      KIND_LBRACKET  = 4'd3,
      KIND_RBRACKET  = 4'd4,
      KIND_POINT     = 4'd5,
      KIND_COLON     = 4'd6,
      KIND_SEMICOLON = 4'd7,
      KIND_COMMA     = 4'd8,
      KIND_NUMBER    = 4'd9,
      KIND_EQUAL     = 4'd10,
      KIND_FN        = 4'd11,
      KIND_TYPE      = 4'd12
   } kind_type;

   // Keyword prefix matched so far within a pending name.
   typedef enum logic [2:0] {
      KW_NONE = 3'd0,
      KW_F    = 3'd1,
      KW_FN   = 3'd2,
      KW_T    = 3'd3,
      KW_TY   = 3'd4,
      KW_TYP  = 3'd5,
      KW_TYPE = 3'd6
   } kw_type;

   typedef struct packed {
      kind_type               kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
      logic [COLUMN_BITS-1:0] length;
      logic                   last;
   } result_type;

   // Up to two results written into the result queue by one beat.
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic                     room;
      logic [FIFO_LVL_BITS-1:0] level;
   } fifo_status_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } punct_type;

   function automatic kw_type kw_first(input logic [7:0] c);
      kw_type r;
      r = KW_NONE;
      if (c == CH_F) r = KW_F;
      else if (c == CH_T) r = KW_T;
      return r;
   endfunction

   function automatic kw_type kw_next(input kw_type p, input logic [7:0] c);
      kw_type r;
      r = KW_NONE;
      case (p)
         KW_F:    if (c == CH_N) r = KW_FN;
         KW_T:    if (c == CH_Y) r = KW_TY;
         KW_TY:   if (c == CH_P) r = KW_TYP;
         KW_TYP:  if (c == CH_E) r = KW_TYPE;
         default: r = KW_NONE;
      endcase
      return r;
   endfunction

   function automatic punct_type punct_lookup(input logic [7:0] c);
      punct_type r;
      r.hit  = 1'b1;
      r.kind = KIND_NAME;
      case (c)
         CH_LBRACE:    r.kind = KIND_LBRACE;
         CH_RBRACE:    r.kind = KIND_RBRACE;
         CH_LPAREN:    r.kind = KIND_LBRACKET;
         CH_RPAREN:    r.kind = KIND_RBRACKET;
         CH_POINT:     r.kind = KIND_POINT;
         CH_COLON:     r.kind = KIND_COLON;
         CH_SEMICOLON: r.kind = KIND_SEMICOLON;
         CH_COMMA:     r.kind = KIND_COMMA;
         CH_EQUAL:     r.kind = KIND_EQUAL;
         default:      r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/slc_core.sv
// Lexer state and per-byte token boundary logic; one byte per beat.
// Depends on slc_pkg; feeds slc_fifo with up to two results per beat.
`default_nettype none

module slc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    ch,
   input  logic                          flush,
   input  logic                          line_load,
   input  logic [slc_pkg::LINE_BITS-1:0] line_value,
   output slc_pkg::push_type             push
);
   import slc_pkg::*;

   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic                   active_ff, active_in;
   logic                   class_ff, class_in;
   logic [COLUMN_BITS-1:0] start_ff, start_in;
   logic [COLUMN_BITS-1:0] len_ff, len_in;
   kw_type                 kw_ff, kw_in;

   logic [COLUMN_BITS-1:0] col;
   logic                   is_name, is_digit;
   punct_type              punct;
   result_type             pend_res, punct_res;
   logic                   v0, v1;
   result_type             r0, r1;

   always_comb begin
      col      = (column_ff == COL_MAX) ? COL_MAX : column_ff + 1'b1;
      is_name  = (ch inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z], CH_UNDERSCORE});
      is_digit = (ch inside {[CH_DIGIT_0:CH_DIGIT_9]});
      punct    = punct_lookup(ch);

      pend_res.line   = line_ff;
      pend_res.column = start_ff;
      pend_res.length = len_ff;
      pend_res.last   = 1'b0;
      if (class_ff == CLASS_NUMBER) pend_res.kind = KIND_NUMBER;
      else if (kw_ff == KW_FN)      pend_res.kind = KIND_FN;
      else if (kw_ff == KW_TYPE)    pend_res.kind = KIND_TYPE;
      else                          pend_res.kind = KIND_NAME;

      punct_res.kind   = punct.kind;
      punct_res.line   = line_ff;
      punct_res.column = col;
      punct_res.length = COLUMN_BITS'(1);
      punct_res.last   = 1'b0;

      line_in   = line_ff;
      column_in = column_ff;
      active_in = active_ff;
      class_in  = class_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      kw_in     = kw_ff;
      v0        = 1'b0;
      v1        = 1'b0;
      r0        = pend_res;
      r1        = punct_res;

      if (accept) begin
         if (flush) begin
            v0        = active_ff;
            active_in = 1'b0;
            len_in    = '0;
            kw_in     = KW_NONE;
         end else if (active_ff && ((is_name && class_ff == CLASS_NAME) ||
                                    (is_digit && class_ff == CLASS_NUMBER))) begin
            // run continues; a saturated name can never be a keyword
            if (len_ff == COL_MAX) kw_in = KW_NONE;
            else if (is_name)      kw_in = kw_next(kw_ff, ch);
            len_in    = (len_ff == COL_MAX) ? COL_MAX : len_ff + 1'b1;
            column_in = col;
         end else begin
            v0        = active_ff;
            active_in = 1'b0;
            len_in    = '0;
            kw_in     = KW_NONE;
            if (is_name || is_digit) begin
               active_in = 1'b1;
               class_in  = is_digit ? CLASS_NUMBER : CLASS_NAME;
               start_in  = col;
               len_in    = COLUMN_BITS'(1);
               kw_in     = is_name ? kw_first(ch) : KW_NONE;
            end else if (punct.hit) begin
               if (active_ff) begin
                  v1 = 1'b1;
               end else begin
                  v0 = 1'b1;
                  r0 = punct_res;
               end
            end
            if (ch == CH_NEWLINE) begin
               line_in   = (line_ff == LINE_MAX) ? LINE_MAX : line_ff + 1'b1;
               column_in = '0;
            end else begin
               column_in = col;
            end
         end
      end

      if (line_load) line_in = line_value;

      r0.last     = v0 && !v1;
      r1.last     = v1;
      push.valid0 = v0;
      push.valid1 = v1;
      push.r0     = r0;
      push.r1     = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= LINE_BITS'(1);
         column_ff <= '0;
         active_ff <= 1'b0;
         class_ff  <= CLASS_NAME;
         start_ff  <= '0;
         len_ff    <= '0;
         kw_ff     <= KW_NONE;
      end else begin
         line_ff   <= line_in;
         column_ff <= column_in;
         active_ff <= active_in;
         class_ff  <= class_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         kw_ff     <= kw_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/slc_fifo.sv
// Small result queue: takes up to two results a beat, gives one a beat.
// Depends on slc_pkg.
`default_nettype none

module slc_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  slc_pkg::push_type        push,
   input  logic                     pop,
   output logic                     out_valid,
   output slc_pkg::result_type      out_data,
   output slc_pkg::fifo_status_type status
);
   import slc_pkg::*;

   result_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_LVL_BITS-1:0] level_ff, level_in;
   logic [FIFO_LVL_BITS-1:0] n_push, n_pop;
   logic [FIFO_PTR_BITS-1:0] wr_next;

   always_comb begin
      n_push   = FIFO_LVL_BITS'(push.valid0) + FIFO_LVL_BITS'(push.valid1);
      n_pop    = FIFO_LVL_BITS'(pop && out_valid);
      wr_next  = wr_ff + 1'b1;
      wr_in    = wr_ff + n_push[FIFO_PTR_BITS-1:0];
      rd_in    = rd_ff + n_pop[FIFO_PTR_BITS-1:0];
      level_in = level_ff + n_push - n_pop;
   end

   assign out_valid    = (level_ff != '0);
   assign out_data     = entry_ff[rd_ff];
   assign status.level = level_ff;
   // room for a full two-result beat, judged on the registered level
   assign status.room  = (level_ff <= FIFO_LVL_BITS'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.valid0) entry_ff[wr_ff]   <= push.r0;
      if (push.valid1) entry_ff[wr_next] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/source_lexer_token_classifier.sv
// Top level of the source lexer token classifier: CSR port, lexer core,
// result queue and assertions. Depends on slc_pkg, slc_core, slc_fifo.
//
// Use:
//   req channel: one source byte per beat. req_tdata[7:0] is the byte,
//     req_tuser[0] is flush (end of input: byte ignored, pending token out).
//   rsp channel: one token per beat, kind/line/column/length in rsp_tdata,
//     rsp_tlast high on the final token caused by a given input byte.
//   csr port: APB style, one register (start_line) at byte address 0.
//     Writing it also loads the running line count. Write only when idle.
// Timing:
//   A byte is classified in the cycle it is taken; its tokens sit in the
//   result queue from the next cycle, with rsp_tvalid high. Throughput is
//   one byte per cycle while the queue has room. A byte that closes a token
//   and is itself punctuation yields two beats, so a long run of such bytes
//   drains at one token per cycle if rsp_tready is high; req_tready is
//   held low while the four-entry queue lacks room for two results.
// Reset: synchronous; line count returns to 1, column and pending token
//   clear, queue empties. A stalled receiver simply fills the queue and
//   then back-pressures the byte stream; nothing is dropped.
`default_nettype none

module source_lexer_token_classifier (
   input  logic                              clock,
   input  logic                              reset,
   // byte stream: tdata [7:0] ch
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // tuser [0] flush
   input  logic [0:0]                        req_tuser,
   // tokens: tdata [3:0] token_kind, [35:4] line_number,
   //   [51:36] column_number, [67:52] token_length, rest zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [slc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [slc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [slc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import slc_pkg::*;

`include "source_lexer_token_classifier_macros.svh"

   logic [CSR_DATA_BITS-1:0] start_line_ff;
   logic                     csr_hit;
   logic                     csr_wr;
   logic                     req_accept;
   push_type                 push;
   result_type               head;
   fifo_status_type          fstat;

   // ---- configuration register ----
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_START_LINE);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? start_line_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_line_ff <= CSR_DATA_BITS'(1);
      end else if (csr_wr) begin
         start_line_ff <= csr_pwdata;
      end
   end

   // ---- byte intake: gated only by queue room, never by a busy state ----
   assign req_tready = fstat.room;
   assign req_accept = req_tvalid && req_tready;

   slc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .ch         (req_tdata),
      .flush      (req_tuser[0]),
      .line_load  (csr_wr),
      .line_value (LINE_BITS'(csr_pwdata)),
      .push       (push)
   );

   // ---- result queue, acts as the output register ----
   slc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (head),
      .status    (fstat)
   );

   assign rsp_tdata = RSP_DATA_BITS'({head.length, head.column, head.line, head.kind});
   assign rsp_tlast = head.last;

   // ---- assertions ----
   `SLC_ASSERT_IMP(a_second_needs_first, push.valid1, push.valid0, "second result without first")
   `SLC_ASSERT_IMP(a_push_only_on_beat, push.valid0 || push.valid1, req_accept, "result without input beat")
   `SLC_ASSERT_IMP(a_flush_single, req_accept && req_tuser[0], !push.valid1, "flush gave two results")
   `SLC_ASSERT_ALWAYS(a_level_bound, fstat.level <= FIFO_LVL_BITS'(FIFO_DEPTH), "result queue overrun")

endmodule

`default_nettype wire

// File: tb/sv/source_lexer_token_classifier_test.sv
// Self-checking testbench for source_lexer_token_classifier: byte stream in, tokens out.
// Depends on slc_pkg and the block's RTL; its own lexer model predicts every token beat.
`default_nettype none

module source_lexer_token_classifier_test;
   import slc_pkg::*;

   // Offsets of the token fields inside rsp_tdata, lowest field first.
   localparam int LINE_LO = KIND_BITS;
   localparam int COL_LO  = KIND_BITS + LINE_BITS;
   localparam int LEN_LO  = COL_LO + COLUMN_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] START_LINE_ADDR =
      CSR_ADDR_BITS'(int'(REG_START_LINE) * 4);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Watchdog limit; this leaves a wide margin over the worst case.
   localparam int CYCLE_LIMIT = 1200000;

   typedef struct {
      logic [7:0] ch;
      logic       flush;
   } src_byte_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;
   logic [0:0]               req_tuser   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   source_lexer_token_classifier u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Lexer model: own copy of the block's state, advanced on every accepted beat.
   // ---------------------------------------------------------------------------
   logic [LINE_BITS-1:0]   start_line_val = LINE_BITS'(1);
   logic [LINE_BITS-1:0]   line_cnt       = LINE_BITS'(1);
   logic [COLUMN_BITS-1:0] col_pos        = '0;   // bytes consumed on this line
   logic                   pend_on        = 1'b0;
   logic                   pend_num       = 1'b0; // pending run is a number, else a name
   logic [COLUMN_BITS-1:0] pend_col       = '0;
   logic [COLUMN_BITS-1:0] pend_len       = '0;
   kw_type                 kw_state       = KW_NONE;

   result_type             token_q[$];   // tokens still due on the rsp channel
   src_byte_type           src_q[$];     // source bytes not yet handed to the driver
   int                     queued_total = 0;
   int                     fail_count   = 0;
   int                     cycle_count  = 0;
   bit                     no_gaps      = 1'b0;

   function automatic kw_type kw_advance(input kw_type p, input logic [7:0] c);
      kw_type r;
      r = KW_NONE;
      if (p == KW_F && c == CH_N) r = KW_FN;
      else if (p == KW_T && c == CH_Y) r = KW_TY;
      else if (p == KW_TY && c == CH_P) r = KW_TYP;
      else if (p == KW_TYP && c == CH_E) r = KW_TYPE;
      return r;
   endfunction

   function automatic bit punct_code(input logic [7:0] c, output kind_type k);
      bit hit;
      hit = 1'b1;
      k   = KIND_NAME;
      case (c)
         CH_LBRACE:    k = KIND_LBRACE;
         CH_RBRACE:    k = KIND_RBRACE;
         CH_LPAREN:    k = KIND_LBRACKET;
         CH_RPAREN:    k = KIND_RBRACKET;
         CH_POINT:     k = KIND_POINT;
         CH_COLON:     k = KIND_COLON;
         CH_SEMICOLON: k = KIND_SEMICOLON;
         CH_COMMA:     k = KIND_COMMA;
         CH_EQUAL:     k = KIND_EQUAL;
         default:      hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic result_type make_token(input kind_type k, input logic [COLUMN_BITS-1:0] c,
                                             input logic [COLUMN_BITS-1:0] n);
      result_type t;
      t.kind   = k;
      t.line   = line_cnt;   // line count at the moment the token is closed
      t.column = c;
      t.length = n;
      t.last   = 1'b0;
      return t;
   endfunction

   // Close the pending name or number, if any; keywords are resolved here.
   task automatic close_token(ref result_type step[$]);
      kind_type k;
      if (pend_on) begin
         if (pend_num) k = KIND_NUMBER;
         else if (kw_state == KW_FN) k = KIND_FN;
         else if (kw_state == KW_TYPE) k = KIND_TYPE;
         else k = KIND_NAME;
         step.insert(step.size(), make_token(k, pend_col, pend_len));
         pend_on  = 1'b0;
         pend_len = '0;
         kw_state = KW_NONE;
      end
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic fl);
      result_type             step[$];
      logic [COLUMN_BITS-1:0] col;
      logic                   is_name;
      logic                   is_num;
      kind_type               pk;
      if (fl) begin
         // end of input: byte ignored, line and column untouched
         close_token(step);
      end else begin
         col     = (col_pos == COL_MAX) ? COL_MAX : col_pos + 1'b1;
         is_name = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                   (c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDERSCORE;
         is_num  = c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
         if (pend_on && ((is_name && !pend_num) || (is_num && pend_num))) begin
            // same class: the run grows; a saturated name can no longer be a keyword
            if (pend_len == COL_MAX) kw_state = KW_NONE;
            else if (is_name) kw_state = kw_advance(kw_state, c);
            if (pend_len != COL_MAX) pend_len = pend_len + 1'b1;
            col_pos = col;
         end else begin
            close_token(step);
            if (is_name || is_num) begin
               pend_on  = 1'b1;
               pend_num = is_num;
               pend_col = col;
               pend_len = COLUMN_BITS'(1);
               if (is_name && c == CH_F) kw_state = KW_F;
               else if (is_name && c == CH_T) kw_state = KW_T;
               else kw_state = KW_NONE;
            end else if (punct_code(c, pk)) begin
               step.insert(step.size(), make_token(pk, col, COLUMN_BITS'(1)));
            end
            if (c == CH_NEWLINE) begin
               if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
               col_pos = '0;
            end else begin
               col_pos = col;
            end
         end
      end
      if (step.size() > 0) step[step.size()-1].last = 1'b1;
      foreach (step[i]) token_q.insert(token_q.size(), step[i]);
   endtask

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Driver: feeds src_q onto the req channel, with a random gap before each
   // beat and bursts of back-to-back beats.
   // ---------------------------------------------------------------------------
   int           send_wait  = 0;
   bit           send_burst = 1'b0;
   src_byte_type send_next;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata, req_tuser[0]);
            if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
            send_wait = (no_gaps || send_burst) ? 0 : $urandom_range(0, 15);
         end
         // only move on once the current beat has gone
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (src_q.size() > 0) begin
               send_next = src_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= send_next.ch;
               req_tuser  <= send_next.flush;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random stall after each token beat; every beat is checked
   // against the oldest predicted token.
   // ---------------------------------------------------------------------------
   int         recv_wait  = 0;
   bit         recv_burst = 1'b0;
   result_type want_tok;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_q.size() == 0) begin
               report("token beat with nothing expected", rsp_tdata[KIND_BITS-1:0], 0);
            end else begin
               want_tok = token_q.pop_front();
               if (rsp_tdata[KIND_BITS-1:0] != want_tok.kind)
                  report("token_kind", rsp_tdata[KIND_BITS-1:0], want_tok.kind);
               if (rsp_tdata[LINE_LO +: LINE_BITS] != want_tok.line)
                  report("line_number", rsp_tdata[LINE_LO +: LINE_BITS], want_tok.line);
               if (rsp_tdata[COL_LO +: COLUMN_BITS] != want_tok.column)
                  report("column_number", rsp_tdata[COL_LO +: COLUMN_BITS], want_tok.column);
               if (rsp_tdata[LEN_LO +: COLUMN_BITS] != want_tok.length)
                  report("token_length", rsp_tdata[LEN_LO +: COLUMN_BITS], want_tok.length);
               if (rsp_tlast !== want_tok.last)
                  report("last_of_run", rsp_tlast, want_tok.last);
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d tokens outstanding", $time, token_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   string      kw_words[10] = '{"fn", "type", "f", "t", "ty", "typ", "fnx", "types",
                                "Fn", "TYPE"};
   logic [7:0] punct_chars[9] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_POINT,
                                  CH_COLON, CH_SEMICOLON, CH_COMMA, CH_EQUAL};

   task automatic push_byte(input logic [7:0] c, input logic fl);
      src_byte_type b;
      b.ch    = c;
      b.flush = fl;
      src_q.insert(src_q.size(), b);
      queued_total++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   task automatic push_run(input logic [7:0] c, input int n);
      repeat (n) push_byte(c, 1'b0);
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'(CH_LOWER_A + r);
      if (r < 52) return 8'(CH_UPPER_A + (r - 26));
      return CH_UNDERSCORE;
   endfunction

   // Mostly well-formed source text: words, numbers, punctuation and
   // separators, with stray bytes and mid-stream flushes mixed in.
   task automatic gen_source(input int n);
      int target;
      int r;
      target = queued_total + n;
      while (queued_total < target) begin
         r = $urandom_range(0, 99);
         if (r < 12) push_text(kw_words[$urandom_range(0, 9)]);
         else if (r < 30) repeat ($urandom_range(1, 8)) push_byte(rand_letter(), 1'b0);
         else if (r < 42)
            repeat ($urandom_range(1, 6))
               push_byte(8'(CH_DIGIT_0 + $urandom_range(0, 9)), 1'b0);
         else if (r < 62) push_byte(punct_chars[$urandom_range(0, 8)], 1'b0);
         else if (r < 78)
            repeat ($urandom_range(1, 3))
               push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
         else if (r < 86) push_byte(CH_NEWLINE, 1'b0);
         else if (r < 95) push_byte(8'($urandom_range(0, 255)), 1'b0);
         else push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      push_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Wait for every queued byte to go in and every token to come out,
   // then pause so that a trailing flush that yields nothing is through too.
   task automatic settle();
      do @(negedge clock);
      while (src_q.size() != 0 || req_tvalid || token_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Setup then access cycle; the write also reloads the line count.
   task automatic csr_write(input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= START_LINE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      start_line_val = value;
      line_cnt       = value;
   endtask

   task automatic csr_check();
      logic [CSR_DATA_BITS-1:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= START_LINE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got != start_line_val) report("start_line read back", got, start_line_val);
   endtask

   task automatic new_phase(input logic [CSR_DATA_BITS-1:0] value);
      settle();
      csr_write(value);
      csr_check();
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check();   // reset value of start_line

      // Directed: keywords, name then number then punctuation (two beats),
      // name next to number, every punctuation byte, stray bytes, flushes.
      push_text("fn type\ta1(9z_;\n{}.:,=)");
      push_byte(8'hff, 1'b0);
      push_text("Tx");
      push_byte(8'h80, 1'b1);
      push_byte(8'h00, 1'b1);   // nothing pending

      new_phase(0);
      gen_source(450);

      // Line count saturates at the top.
      new_phase(32'hffff_fffe);
      gen_source(300);
      push_text("\n\n\nab\n;");
      push_byte(8'h00, 1'b1);

      // Long name and a wide gap of spaces, sent back to back.
      new_phase(32'd77);
      no_gaps = 1'b1;
      push_run(CH_LOWER_A, 40);
      push_text("(7 \n");
      push_run(CH_SPACE, 20);
      push_text("bcd;\nfn");
      push_byte(8'h55, 1'b1);
      settle();
      no_gaps = 1'b0;

      new_phase(32'hffff_ffff);
      gen_source(300);

      new_phase(1);
      gen_source(600);

      new_phase($urandom_range(2, 1000));
      gen_source(300);

      settle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && token_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
